// File: hdl/assert_macros.svh
// assertion macros used by the scheduler core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define CHK_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define CHK_ASSERT(lbl, prop)
`define CHK_NEVER(lbl, expr)
`endif
`endif

// File: hdl/msched_pkg.sv
// types and constants of the multi cpu process scheduler
`default_nettype none
package msched_pkg;

  typedef enum logic [1:0] {
    ST_WAIT  = 2'd0,
    ST_RUN   = 2'd1,
    ST_SLEEP = 2'd2,
    ST_DONE  = 2'd3
  } stat_e;

  localparam logic [1:0] MODE_RR   = 2'd0;
  localparam logic [1:0] MODE_FCFS = 2'd1;
  localparam logic [1:0] MODE_SJF  = 2'd2;
  localparam logic [1:0] MODE_OFF  = 2'd3;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_PROCS = 2'd1;
  localparam logic [1:0] REG_CPUS  = 2'd2;
  localparam logic [1:0] REG_SLICE = 2'd3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam int ResultCap = 32;

  typedef struct packed {
    logic       action;
    logic [4:0] proc_slot;
    logic [7:0] burst_len;
    logic [7:0] io_point;
    logic [7:0] io_len;
  } in_t;

  typedef struct packed {
    logic [4:0] slot_id;
    logic [1:0] run_state;
    logic [7:0] work_left;
    logic [3:0] on_cpu;
    logic       all_finished;
    logic       last_slot;
  } res_t;

  // one process table entry
  typedef struct packed {
    stat_e       status;
    logic [7:0]  cpu_left;
    logic [7:0]  sleep_point;
    logic [7:0]  sleep_left;
    logic [7:0]  slice_used;
    logic [15:0] ready_since;
    logic [3:0]  host_cpu;
  } ent_t;

endpackage
`default_nettype wire

// File: hdl/multi_cpu_process_scheduler_core.sv
// top level of the multi cpu process scheduler
// Input channel (in_valid_i/in_ready_o, in_item_i) takes load and tick
// items; the output channel (out_valid_o/out_ready_i, out_item_o) returns
// one item per slot in use after every tick, slot 0 first, last_slot on the
// final one. A load returns nothing.
// A tick is worked through the process table ram one entry access at a
// time: a wake pass reads and writes back each slot, a run pass updates
// the entry held by each busy cpu, a dispatch scan runs for each free
// cpu unless n is 0 or the mode is off (after a pointer reduction in
// round robin), then a completion scan over the slots, and last the
// results go out one by one. The slot count n is capped at 32.
// A stalled receiver holds the block in its output state; a new item is
// taken only after the last result of a tick has gone out.
// Reset sets the registers to round robin, 4 slots, 1 cpu, quantum 2,
// frees all cpus and marks every table entry unwritten (reads as waiting
// with zero counters); no clearing pass is needed.
// Configuration writes are taken at any time on cfg_we_i.
`default_nettype none
`include "assert_macros.svh"
module multi_cpu_process_scheduler_core
  import msched_pkg::*;
#(
  parameter int MAX_PROCS = 32,
  parameter int MAX_CPUS  = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_t        in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output res_t            out_item_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);

  localparam int PW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int NW   = $clog2(MAX_PROCS + 1);
  localparam int NLIM = (MAX_PROCS < ResultCap) ? MAX_PROCS : ResultCap;
  localparam int CIW  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int CNW  = $clog2(MAX_CPUS + 1);
  localparam int EW   = $bits(ent_t);

  typedef enum logic [3:0] {
    S_IDLE, S_WK_RD, S_WK_WR, S_RN_CHK, S_RN_WR, S_DS_CHK, S_DS_MOD,
    S_DS_SCAN, S_DS_RD, S_DS_WR, S_DN_SCAN, S_EM_RD, S_EM_LD, S_EM_WAIT
  } st_e;

  st_e              state_q;
  logic [1:0]       mode_q;
  logic [5:0]       pcount_q;
  logic [4:0]       ccount_q;
  logic [7:0]       slen_q;
  logic             valid_q [MAX_PROCS];
  logic             busy_q  [MAX_CPUS];
  logic [PW-1:0]    holder_q [MAX_CPUS];
  logic [15:0]      clock_q;
  logic [PW-1:0]    ptr_q;
  logic [PW-1:0]    ptrm_q;
  logic [NW-1:0]    idx_q;
  logic [PW-1:0]    addr_q;
  logic [CNW-1:0]   cpu_q;
  logic             pend_q;
  logic [PW-1:0]    pend_addr_q;
  logic             found_q;
  logic [PW-1:0]    best_q;
  logic [15:0]      key_q;
  logic             done_q;
  logic             rd_vld_q;
  logic             out_valid_q;
  res_t             out_q;

  logic [NW-1:0]    n;
  logic [CNW-1:0]   nc;
  logic [CIW-1:0]   ci;
  logic             slot_ok;
  logic             issue;
  logic [PW-1:0]    addr_nx;
  logic             take;
  logic [15:0]      cand_key;
  logic             rn_free;
  logic [7:0]       su;
  ent_t             ent;
  ent_t             wr_ent;
  logic             rd_en, we;
  logic [PW-1:0]    rd_addr, waddr;
  logic [EW-1:0]    rd_data;

  assign n  = (pcount_q > 6'(NLIM)) ? NW'(NLIM) : NW'(pcount_q);
  assign nc = (ccount_q > 5'(MAX_CPUS)) ? CNW'(MAX_CPUS) : CNW'(ccount_q);
  assign ci = cpu_q[CIW-1:0];
  assign slot_ok = (32'(in_item_i.proc_slot) < MAX_PROCS);
  assign issue = (idx_q != n);
  assign addr_nx = ((NW'(addr_q) + 1'b1) == n) ? '0 : addr_q + 1'b1;
  assign ent = rd_vld_q ? ent_t'(rd_data) : ent_t'('0);
  assign cand_key = (mode_q == MODE_FCFS) ? ent.ready_since : 16'(ent.cpu_left);
  assign su = (ent.slice_used == 8'hff) ? 8'hff : ent.slice_used + 8'd1;

  always_comb begin
    take = 1'b0;
    if (ent.status == ST_WAIT) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (mode_q == MODE_FCFS || mode_q == MODE_SJF) begin
        take = cand_key < key_q;
      end
    end
  end

  // ram port control and the read-modify-write update of each phase
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr_q;
    we      = 1'b0;
    waddr   = PW'(idx_q);
    wr_ent  = ent;
    rn_free = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        we    = in_valid_i && (in_item_i.action == ACT_LOAD) && slot_ok;
        waddr = PW'(in_item_i.proc_slot);
        wr_ent.status      = ST_WAIT;
        wr_ent.cpu_left    = in_item_i.burst_len;
        wr_ent.sleep_point = in_item_i.io_point;
        wr_ent.sleep_left  = in_item_i.io_len;
        wr_ent.slice_used  = '0;
        wr_ent.ready_since = '0;
        wr_ent.host_cpu    = '0;
      end
      S_WK_RD: begin
        rd_en   = issue;
        rd_addr = PW'(idx_q);
      end
      S_WK_WR: begin
        we = 1'b1;
        if (ent.status == ST_SLEEP) begin
          if (ent.sleep_left <= 8'd1) begin
            wr_ent.sleep_left  = '0;
            wr_ent.status      = ST_WAIT;
            wr_ent.ready_since = clock_q;
          end else begin
            wr_ent.sleep_left = ent.sleep_left - 8'd1;
          end
        end
      end
      S_RN_CHK: begin
        rd_en   = (cpu_q != nc) && busy_q[ci];
        rd_addr = holder_q[ci];
      end
      S_RN_WR: begin
        we = 1'b1;
        waddr = holder_q[ci];
        wr_ent.slice_used = su;
        if (ent.cpu_left <= 8'd1) begin
          wr_ent.cpu_left = '0;
          wr_ent.status   = ST_DONE;
          rn_free = 1'b1;
        end else begin
          wr_ent.cpu_left = ent.cpu_left - 8'd1;
          if (wr_ent.cpu_left == ent.sleep_point) begin
            wr_ent.status = ST_SLEEP;
            rn_free = 1'b1;
          end else if (mode_q == MODE_RR && su >= slen_q) begin
            wr_ent.status      = ST_WAIT;
            wr_ent.ready_since = clock_q;
            rn_free = 1'b1;
          end
        end
      end
      S_DS_SCAN, S_DN_SCAN: begin
        rd_en   = issue;
        rd_addr = addr_q;
      end
      S_DS_RD: begin
        rd_en   = 1'b1;
        rd_addr = best_q;
      end
      S_DS_WR: begin
        we = 1'b1;
        waddr = best_q;
        wr_ent.status     = ST_RUN;
        wr_ent.slice_used = '0;
        wr_ent.host_cpu   = 4'(ci);
      end
      S_EM_RD: begin
        rd_en   = 1'b1;
        rd_addr = PW'(idx_q);
      end
      default: begin
      end
    endcase
  end

  msched_ram #(
    .Width(EW),
    .Depth(MAX_PROCS)
  ) u_tbl (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(EW'(wr_ent)),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_RR;
      pcount_q    <= 6'd4;
      ccount_q    <= 5'd1;
      slen_q      <= 8'd2;
      valid_q     <= '{default: 1'b0};
      busy_q      <= '{default: 1'b0};
      holder_q    <= '{default: '0};
      clock_q     <= '0;
      ptr_q       <= '0;
      ptrm_q      <= '0;
      idx_q       <= '0;
      addr_q      <= '0;
      cpu_q       <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      key_q       <= '0;
      done_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MODE:  mode_q   <= cfg_wdata_i[1:0];
          REG_PROCS: pcount_q <= cfg_wdata_i[5:0];
          REG_CPUS:  ccount_q <= cfg_wdata_i[4:0];
          REG_SLICE: slen_q   <= cfg_wdata_i;
        endcase
      end
      if (rd_en) begin
        rd_vld_q <= valid_q[rd_addr];
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_item_i.action == ACT_LOAD) begin
              if (slot_ok) begin
                valid_q[PW'(in_item_i.proc_slot)] <= 1'b1;
                for (int c = 0; c < MAX_CPUS; c++) begin
                  if (busy_q[c] && holder_q[c] == PW'(in_item_i.proc_slot)) begin
                    busy_q[c] <= 1'b0;
                  end
                end
                clock_q <= '0;
                ptr_q   <= '0;
              end
            end else begin
              idx_q   <= '0;
              state_q <= S_WK_RD;
            end
          end
        end
        S_WK_RD: begin
          if (!issue) begin
            cpu_q   <= '0;
            state_q <= S_RN_CHK;
          end else begin
            state_q <= S_WK_WR;
          end
        end
        S_WK_WR: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= S_WK_RD;
        end
        S_RN_CHK: begin
          if (cpu_q == nc) begin
            cpu_q   <= '0;
            state_q <= S_DS_CHK;
          end else if (!busy_q[ci]) begin
            cpu_q <= cpu_q + 1'b1;
          end else begin
            state_q <= S_RN_WR;
          end
        end
        S_RN_WR: begin
          if (rn_free) begin
            busy_q[ci] <= 1'b0;
          end
          cpu_q   <= cpu_q + 1'b1;
          state_q <= S_RN_CHK;
        end
        S_DS_CHK: begin
          if (cpu_q == nc) begin
            clock_q <= clock_q + 16'd1;
            idx_q   <= '0;
            addr_q  <= '0;
            pend_q  <= 1'b0;
            done_q  <= 1'b1;
            state_q <= S_DN_SCAN;
          end else if (busy_q[ci] || n == '0 || mode_q == MODE_OFF) begin
            cpu_q <= cpu_q + 1'b1;
          end else begin
            found_q <= 1'b0;
            pend_q  <= 1'b0;
            idx_q   <= '0;
            addr_q  <= '0;
            ptrm_q  <= ptr_q;
            state_q <= (mode_q == MODE_RR) ? S_DS_MOD : S_DS_SCAN;
          end
        end
        S_DS_MOD: begin
          // bring the rotation pointer below the slot count
          if (NW'(ptrm_q) >= n) begin
            ptrm_q <= ptrm_q - PW'(n);
          end else begin
            addr_q  <= ptrm_q;
            state_q <= S_DS_SCAN;
          end
        end
        S_DS_SCAN: begin
          pend_q      <= issue;
          pend_addr_q <= addr_q;
          if (issue) begin
            idx_q  <= idx_q + 1'b1;
            addr_q <= addr_nx;
          end
          if (pend_q && take) begin
            found_q <= 1'b1;
            best_q  <= pend_addr_q;
            key_q   <= cand_key;
          end
          if (!issue && !pend_q) begin
            if (found_q) begin
              state_q <= S_DS_RD;
            end else begin
              cpu_q   <= cpu_q + 1'b1;
              state_q <= S_DS_CHK;
            end
          end
        end
        S_DS_RD: begin
          state_q <= S_DS_WR;
        end
        S_DS_WR: begin
          busy_q[ci]   <= 1'b1;
          holder_q[ci] <= best_q;
          if (mode_q == MODE_RR) begin
            ptr_q <= ((NW'(best_q) + 1'b1) == n) ? '0 : best_q + 1'b1;
          end
          cpu_q   <= cpu_q + 1'b1;
          state_q <= S_DS_CHK;
        end
        S_DN_SCAN: begin
          pend_q <= issue;
          if (issue) begin
            idx_q  <= idx_q + 1'b1;
            addr_q <= addr_nx;
          end
          if (pend_q && ent.status != ST_DONE) begin
            done_q <= 1'b0;
          end
          if (!issue && !pend_q) begin
            idx_q   <= '0;
            state_q <= (n == '0) ? S_IDLE : S_EM_RD;
          end
        end
        S_EM_RD: begin
          state_q <= S_EM_LD;
        end
        S_EM_LD: begin
          out_q.slot_id      <= 5'(idx_q);
          out_q.run_state    <= ent.status;
          out_q.work_left    <= ent.cpu_left;
          out_q.on_cpu       <= (ent.status == ST_RUN) ? ent.host_cpu : 4'd0;
          out_q.all_finished <= done_q;
          out_q.last_slot    <= (idx_q + 1'b1) == n;
          out_valid_q        <= 1'b1;
          state_q            <= S_EM_WAIT;
        end
        S_EM_WAIT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            idx_q       <= idx_q + 1'b1;
            state_q     <= ((idx_q + 1'b1) == n) ? S_IDLE : S_EM_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `CHK_NEVER(a_no_accept_while_out, in_ready_o && out_valid_o)
  `CHK_ASSERT(a_last_returns_idle,
    out_valid_o && out_ready_i && out_item_o.last_slot |=> in_ready_o)
  `CHK_ASSERT(a_pick_is_waiting, state_q == S_DS_WR |-> ent.status == ST_WAIT)
  `CHK_ASSERT(a_ptr_in_range, 32'(ptr_q) < MAX_PROCS)

endmodule
`default_nettype wire

// File: hdl/msched_ram.sv
// generic single write port ram with registered read
`default_nettype none
module msched_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: dv/tb_multi_cpu_process_scheduler_core.sv
// testbench for the multi cpu process scheduler core: loads, ticks and slot state checks
`default_nettype none
module tb_multi_cpu_process_scheduler_core;
  import msched_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // state table of the scheduler and the slot states it owes
  class sched_board;
    logic [1:0]  mode;
    logic [5:0]  nprocs;
    logic [4:0]  ncpus;
    logic [7:0]  slice;
    stat_e       status [32];
    logic [7:0]  left [32];
    logic [7:0]  iopt [32];
    logic [7:0]  sleep [32];
    logic [7:0]  used [32];
    logic [15:0] since [32];
    logic [3:0]  host [32];
    logic [4:0]  holder [16];
    bit          busy [16];
    logic [15:0] clock;
    logic [4:0]  rptr;
    res_t        owed [$];
    int          errors;

    function new();
      mode = MODE_RR; nprocs = 4; ncpus = 1; slice = 2;
      for (int i = 0; i < 32; i++) begin
        status[i] = ST_WAIT; left[i] = 0; iopt[i] = 0; sleep[i] = 0;
        used[i] = 0; since[i] = 0; host[i] = 0;
      end
      for (int c = 0; c < 16; c++) begin
        holder[c] = 0; busy[c] = 0;
      end
      clock = 0; rptr = 0; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        REG_MODE:  mode = v[1:0];
        REG_PROCS: nprocs = v[5:0];
        REG_CPUS:  ncpus = v[4:0];
        default:   slice = v;
      endcase
    endfunction

    function int pick_next(int n);
      int best;
      best = -1;
      if (n == 0) return -1;
      if (mode == MODE_RR) begin
        for (int i = 0; i < n; i++) begin
          int idx;
          idx = (rptr + i) % n;
          if (status[idx] == ST_WAIT) begin
            rptr = 5'((idx + 1) % n);
            return idx;
          end
        end
      end else if (mode == MODE_FCFS) begin
        for (int i = 0; i < n; i++)
          if (status[i] == ST_WAIT && (best < 0 || since[i] < since[best])) best = i;
      end else if (mode == MODE_SJF) begin
        for (int i = 0; i < n; i++)
          if (status[i] == ST_WAIT && (best < 0 || left[i] < left[best])) best = i;
      end
      return best;
    endfunction

    function void note_item(in_t it);
      int n, nc, p;
      bit done;
      res_t r;
      n = (nprocs > 32) ? 32 : nprocs;
      nc = (ncpus > 16) ? 16 : ncpus;
      if (it.action == ACT_LOAD) begin
        p = it.proc_slot;
        status[p] = ST_WAIT; left[p] = it.burst_len; iopt[p] = it.io_point;
        sleep[p] = it.io_len; used[p] = 0; since[p] = 0; host[p] = 0;
        for (int c = 0; c < 16; c++)
          if (busy[c] && holder[c] == p) busy[c] = 0;
        clock = 0; rptr = 0;
        return;
      end
      for (int i = 0; i < n; i++)
        if (status[i] == ST_SLEEP) begin
          if (sleep[i] <= 1) begin
            sleep[i] = 0; status[i] = ST_WAIT; since[i] = clock;
          end else sleep[i]--;
        end
      for (int c = 0; c < nc; c++) begin
        if (!busy[c]) continue;
        p = holder[c];
        if (used[p] < 255) used[p]++;
        if (left[p] <= 1) begin
          left[p] = 0; status[p] = ST_DONE; busy[c] = 0;
        end else begin
          left[p]--;
          if (left[p] == iopt[p]) begin
            status[p] = ST_SLEEP; busy[c] = 0;
          end else if (mode == MODE_RR && used[p] >= slice) begin
            status[p] = ST_WAIT; since[p] = clock; busy[c] = 0;
          end
        end
      end
      for (int c = 0; c < nc; c++) begin
        if (busy[c]) continue;
        p = pick_next(n);
        if (p >= 0) begin
          busy[c] = 1; holder[c] = 5'(p); status[p] = ST_RUN; used[p] = 0;
          host[p] = 4'(c);
        end
      end
      clock++;
      done = 1;
      for (int i = 0; i < n; i++) if (status[i] != ST_DONE) done = 0;
      for (int i = 0; i < n; i++) begin
        r.slot_id = 5'(i); r.run_state = status[i]; r.work_left = left[i];
        r.on_cpu = (status[i] == ST_RUN) ? host[i] : 4'd0;
        r.all_finished = done; r.last_slot = (i + 1 == n);
        owed.push_back(r);
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (owed.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (got.slot_id !== e.slot_id) begin
        $error("slot_id exp %0d got %0d", e.slot_id, got.slot_id); errors++;
      end
      if (got.run_state !== e.run_state) begin
        $error("run_state exp %0d got %0d", e.run_state, got.run_state); errors++;
      end
      if (got.work_left !== e.work_left) begin
        $error("work_left exp %0d got %0d", e.work_left, got.work_left); errors++;
      end
      if (got.on_cpu !== e.on_cpu) begin
        $error("on_cpu exp %0d got %0d", e.on_cpu, got.on_cpu); errors++;
      end
      if (got.all_finished !== e.all_finished) begin
        $error("all_finished exp %0d got %0d", e.all_finished, got.all_finished); errors++;
      end
      if (got.last_slot !== e.last_slot) begin
        $error("last_slot exp %0d got %0d", e.last_slot, got.last_slot); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_t  in_item_i;
  res_t out_item_o;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  sched_board board;
  int send_idle, recv_idle;
  bit hold_recv;
  bit loaded [32];

  multi_cpu_process_scheduler_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls, plus an optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_result(out_item_o);
      out_ready_i <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end
  end

  // valid stays high after an accept so that items can follow back to back
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(it);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (board.owed.size() != 0 && guard < 200000) begin
      @(posedge clk_i); guard++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] v);
    in_valid_i <= 1'b0;
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(posedge clk_i);
    board.write_reg(idx, v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_slot(int s, int burst, int iop, int iol);
    in_t it;
    it.action = ACT_LOAD; it.proc_slot = 5'(s); it.burst_len = 8'(burst);
    it.io_point = 8'(iop); it.io_len = 8'(iol);
    send_item(it);
    loaded[s] = 1;
  endtask

  task automatic tick();
    in_t it;
    it = in_t'(30'($urandom()));
    it.action = ACT_TICK;
    send_item(it);
  endtask

  // random config, load slots in use (any unloaded; mostly short bursts), then ticks
  task automatic random_phase(int ticks);
    int np;
    drain();
    write_reg(REG_MODE, 8'($urandom_range(3)));
    np = ($urandom_range(9) == 0) ? 32 : $urandom_range(1, 8);
    write_reg(REG_PROCS, 8'(np));
    write_reg(REG_CPUS, 8'(($urandom_range(7) == 0) ? 16 : $urandom_range(0, 4)));
    write_reg(REG_SLICE,
              8'(($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(0, 4)));
    for (int s = 0; s < np; s++)
      if (!loaded[s] || $urandom_range(3) != 0)
        load_slot(s, ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(0, 12),
                  ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(0, 6),
                  ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(0, 4));
    for (int t = 0; t < ticks; t++) begin
      if ($urandom_range(15) == 0)
        load_slot($urandom_range(np - 1), $urandom_range(255), $urandom_range(255),
                  $urandom_range(255));
      else tick();
    end
  endtask

  initial begin
    board = new();
    rst_ni = 0; in_valid_i = 0; in_item_i = '0; out_ready_i = 0;
    cfg_we_i = 0; cfg_idx_i = REG_MODE; cfg_wdata_i = 0;
    hold_recv = 0; send_idle = 28; recv_idle = 60;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset settings, edge bursts, zero io length, zero quantum
    load_slot(0, 255, 0, 0);
    load_slot(1, 0, 0, 0);
    load_slot(2, 3, 2, 0);
    load_slot(3, 1, 255, 255);
    repeat (6) tick();
    drain();
    write_reg(REG_SLICE, 8'd0);
    write_reg(REG_CPUS, 8'd0);
    tick();
    drain();
    write_reg(REG_CPUS, 8'd31);
    write_reg(REG_PROCS, 8'd63);
    for (int s = 0; s < 32; s++) load_slot(s, s * 8, s[0] ? 8'd2 : 8'd0, 8'd255);
    load_slot(31, 255, 254, 1);
    write_reg(REG_MODE, 8'(MODE_SJF));
    tick(); tick();
    drain();
    write_reg(REG_MODE, 8'(MODE_FCFS));
    write_reg(REG_PROCS, 8'd0);
    tick();
    drain();
    write_reg(REG_MODE, 8'(MODE_OFF));
    write_reg(REG_PROCS, 8'd4);
    write_reg(REG_SLICE, 8'd255);
    tick();
    drain();
    write_reg(REG_MODE, 8'(MODE_RR));
    write_reg(REG_PROCS, 8'd3);
    load_slot(0, 5, 0, 0);

    // long receiver hold while items keep coming
    fork
      begin
        hold_recv = 1;
        repeat (400) @(posedge clk_i);
        hold_recv = 0;
      end
      begin
        repeat (4) tick();
      end
    join

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 28 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 28 : 0;
      for (int k = 0; k < 8; k++) random_phase(12);
    end
    drain();

    if (board.errors == 0 && board.owed.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
